// ===== rtl/core/tlik_pkg.sv =====
package tlik_pkg;

  // Field and register widths
  localparam int COORD_W   = 16;
  localparam int LINK_W    = 13;
  localparam int ANGLE_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_LEN = 2'd1;
  localparam logic [LINK_W-1:0]    LINK_RESET    = 13'd2432;

  // Front end arithmetic
  localparam int SQ_W    = 2*COORD_W - 1;       // x*x
  localparam int DSQ_W   = SQ_W + 1;            // x*x + y*y
  localparam int LSQ_W   = 2*LINK_W;            // l*l
  localparam int DEN_W   = LSQ_W + 1;           // 2*l1*l2, l1*l1 + l2*l2
  localparam int LIM_W   = DEN_W + 1;           // (l1 + l2)^2
  localparam int NUM_W   = DEN_W + 1;           // clamped cosine numerator, signed
  localparam int WIDE_W  = DSQ_W + 2;           // unclamped signed sums
  localparam int NB_W    = LIM_W + 2;           // beta numerator, signed
  localparam int DSQR_W  = 2*DEN_W;             // den^2, num^2
  localparam int NBSQ_W  = 2*NB_W - 2;          // nb^2
  localparam int HYP_W   = LIM_W + LSQ_W;       // dsq * l1^2

  // Square root chain
  localparam int ROOT_W  = 28;
  localparam int RAD_W   = 2*ROOT_W;
  localparam int REM_W   = ROOT_W + 1;
  localparam int CUR_W   = ROOT_W + 3;

  // Angle unit
  localparam int ATAN_IN_W    = 32;
  localparam int NORM_TOP     = 40;
  localparam int M_W          = NORM_TOP + 1;
  localparam int CW           = NORM_TOP + 4;
  localparam int ZW           = 32;
  localparam int NORM_STAGES  = 6;
  localparam int SHAMT_W      = 6;
  localparam int CORDIC_STEPS = 16;
  localparam int IDX_W        = 5;
  localparam int ATAN_LAT     = NORM_STAGES + CORDIC_STEPS + 2;

  localparam logic signed [ZW-1:0]      NINETY_Q   = 32'sd94371840;
  localparam logic signed [ZW-1:0]      ROUND_HALF = 32'sd8192;
  localparam int                        OUT_SHIFT  = 14;
  localparam logic signed [ANGLE_W-1:0] NINETY_OUT = 16'sd5760;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic [M_W-1:0]       m;
    logic                 zero;
  } norm_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } rot_t;

  // atan(2^-i) in degrees * 2^20
  function automatic logic signed [ZW-1:0] atan_q(input logic [IDX_W-1:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      5'd0:    v = 32'sd47185920;
      5'd1:    v = 32'sd27855475;
      5'd2:    v = 32'sd14718068;
      5'd3:    v = 32'sd7471121;
      5'd4:    v = 32'sd3750058;
      5'd5:    v = 32'sd1876857;
      5'd6:    v = 32'sd938658;
      5'd7:    v = 32'sd469357;
      5'd8:    v = 32'sd234682;
      5'd9:    v = 32'sd117342;
      5'd10:   v = 32'sd58671;
      5'd11:   v = 32'sd29335;
      5'd12:   v = 32'sd14668;
      5'd13:   v = 32'sd7334;
      5'd14:   v = 32'sd3667;
      5'd15:   v = 32'sd1833;
      5'd16:   v = 32'sd917;
      5'd17:   v = 32'sd458;
      5'd18:   v = 32'sd229;
      5'd19:   v = 32'sd115;
      5'd20:   v = 32'sd57;
      5'd21:   v = 32'sd29;
      5'd22:   v = 32'sd14;
      5'd23:   v = 32'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/tlik_channels.sv =====
interface tlik_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [tlik_pkg::COORD_W-1:0]    target_x;
  logic signed [tlik_pkg::COORD_W-1:0]    target_y;
  modport source (output valid, target_x, target_y, input ready);
  modport sink   (input valid, target_x, target_y, output ready);
endinterface

interface tlik_out_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   reachable;
  logic signed [tlik_pkg::ANGLE_W-1:0]    hip_angle;
  logic signed [tlik_pkg::ANGLE_W-1:0]    knee_angle;
  logic signed [tlik_pkg::ANGLE_W-1:0]    ankle_angle;
  logic signed [tlik_pkg::ANGLE_W-1:0]    hip_servo_target;
  logic signed [tlik_pkg::ANGLE_W-1:0]    knee_servo_target;
  logic signed [tlik_pkg::ANGLE_W-1:0]    ankle_servo_target;
  modport source (output valid, reachable, hip_angle, knee_angle, ankle_angle,
                  hip_servo_target, knee_servo_target, ankle_servo_target,
                  input ready);
  modport sink   (input valid, reachable, hip_angle, knee_angle, ankle_angle,
                  hip_servo_target, knee_servo_target, ankle_servo_target,
                  output ready);
endinterface

interface tlik_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [tlik_pkg::CFG_IDX_W-1:0]         index;
  logic [tlik_pkg::LINK_W-1:0]            data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/tlik_sqrt_cell.sv =====
module tlik_sqrt_cell (
  input  logic            clk,
  input  logic            en,
  input  tlik_pkg::sqrt_t d,
  output tlik_pkg::sqrt_t q_r
);

  logic [tlik_pkg::CUR_W-1:0] cur;
  logic [tlik_pkg::CUR_W-1:0] trial;
  logic [tlik_pkg::CUR_W-1:0] diff;
  logic                       ge;
  tlik_pkg::sqrt_t            q_nxt;

  // One root bit per cell: bring down two radicand bits, try root*4+1
  always_comb begin
    cur   = {d.rem, d.rad[tlik_pkg::RAD_W-1 -: 2]};
    trial = tlik_pkg::CUR_W'({d.root, 2'b01});
    ge    = (cur >= trial);
    diff  = cur - trial;
    q_nxt.rem  = ge ? tlik_pkg::REM_W'(diff) : tlik_pkg::REM_W'(cur);
    q_nxt.root = {d.root[tlik_pkg::ROOT_W-2:0], ge};
    q_nxt.rad  = {d.rad[tlik_pkg::RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule

// ===== rtl/core/tlik_norm_cell.sv =====
module tlik_norm_cell (
  input  logic                         clk,
  input  logic                         en,
  input  logic [tlik_pkg::SHAMT_W-1:0] shamt,
  input  tlik_pkg::norm_t              d,
  output tlik_pkg::norm_t              q_r
);

  logic [tlik_pkg::M_W-1:0] top_mask;
  logic                     room;
  tlik_pkg::norm_t          q_nxt;

  // Shift left by shamt when the top shamt bits of the magnitude are clear
  always_comb begin
    top_mask = ~({tlik_pkg::M_W{1'b1}} >> shamt);
    room     = ((d.m & top_mask) == '0);
    q_nxt    = d;
    if (room) begin
      q_nxt.a = d.a <<< shamt;
      q_nxt.b = d.b <<< shamt;
      q_nxt.m = d.m << shamt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule

// ===== rtl/core/tlik_cordic_cell.sv =====
module tlik_cordic_cell (
  input  logic                       clk,
  input  logic                       en,
  input  logic [tlik_pkg::IDX_W-1:0] idx,
  input  tlik_pkg::rot_t             d,
  output tlik_pkg::rot_t             q_r
);

  logic signed [tlik_pkg::CW-1:0] xs;
  logic signed [tlik_pkg::CW-1:0] ys;
  logic signed [tlik_pkg::CW-1:0] dx;
  logic signed [tlik_pkg::CW-1:0] dy;
  logic signed [tlik_pkg::ZW-1:0] ang;
  tlik_pkg::rot_t                 q_nxt;

  // Rotate toward the x axis by atan(2^-idx)
  always_comb begin
    xs  = d.x;
    ys  = d.y;
    dx  = xs >>> idx;
    dy  = ys >>> idx;
    ang = tlik_pkg::atan_q(idx);
    q_nxt.zero = d.zero;
    if (!ys[tlik_pkg::CW-1]) begin
      q_nxt.x = xs + dy;
      q_nxt.y = ys - dx;
      q_nxt.z = d.z + ang;
    end else begin
      q_nxt.x = xs - dy;
      q_nxt.y = ys + dx;
      q_nxt.z = d.z - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule

// ===== rtl/core/tlik_atan2.sv =====
module tlik_atan2 (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [tlik_pkg::ATAN_IN_W-1:0] a,
  input  logic signed [tlik_pkg::ATAN_IN_W-1:0] b,
  output logic signed [tlik_pkg::ZW-1:0]        angle
);

  logic [tlik_pkg::ATAN_IN_W-1:0] abs_a;
  logic [tlik_pkg::ATAN_IN_W-1:0] abs_b;
  logic [tlik_pkg::ATAN_IN_W-1:0] mag;
  tlik_pkg::norm_t                prep_nxt;
  tlik_pkg::norm_t                norm_r [0:tlik_pkg::NORM_STAGES];
  tlik_pkg::norm_t                nl;
  tlik_pkg::rot_t                 rot_nxt;
  tlik_pkg::rot_t                 rot_r  [0:tlik_pkg::CORDIC_STEPS];

  // Magnitude for the normalizer, sign-extend the pair
  always_comb begin
    abs_a = a[tlik_pkg::ATAN_IN_W-1] ? unsigned'(-a) : unsigned'(a);
    abs_b = b[tlik_pkg::ATAN_IN_W-1] ? unsigned'(-b) : unsigned'(b);
    mag   = (abs_a > abs_b) ? abs_a : abs_b;
    prep_nxt.a    = tlik_pkg::CW'(a);
    prep_nxt.b    = tlik_pkg::CW'(b);
    prep_nxt.m    = tlik_pkg::M_W'(mag);
    prep_nxt.zero = (mag == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      norm_r[0] <= prep_nxt;
    end
  end

  for (genvar g = 0; g < tlik_pkg::NORM_STAGES; g++) begin : g_norm
    tlik_norm_cell u_norm (
      .clk   (clk),
      .en    (en),
      .shamt (tlik_pkg::SHAMT_W'(1 << (tlik_pkg::NORM_STAGES - 1 - g))),
      .d     (norm_r[g]),
      .q_r   (norm_r[g+1])
    );
  end

  // Fold the left half plane into the right one
  always_comb begin
    nl = norm_r[tlik_pkg::NORM_STAGES];
    rot_nxt.zero = nl.zero;
    if (nl.b[tlik_pkg::CW-1]) begin
      if (!nl.a[tlik_pkg::CW-1]) begin
        rot_nxt.x = nl.a;
        rot_nxt.y = -nl.b;
        rot_nxt.z = tlik_pkg::NINETY_Q;
      end else begin
        rot_nxt.x = -nl.a;
        rot_nxt.y = nl.b;
        rot_nxt.z = -tlik_pkg::NINETY_Q;
      end
    end else begin
      rot_nxt.x = nl.b;
      rot_nxt.y = nl.a;
      rot_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r[0] <= rot_nxt;
    end
  end

  for (genvar g = 0; g < tlik_pkg::CORDIC_STEPS; g++) begin : g_cordic
    tlik_cordic_cell u_cordic (
      .clk (clk),
      .en  (en),
      .idx (tlik_pkg::IDX_W'(g)),
      .d   (rot_r[g]),
      .q_r (rot_r[g+1])
    );
  end

  assign angle = rot_r[tlik_pkg::CORDIC_STEPS].zero ? '0
                                                    : rot_r[tlik_pkg::CORDIC_STEPS].z;

endmodule

// ===== rtl/core/two_link_leg_inverse_kinematics.sv =====
// Channel  | Dir | Transfer carries
// ---------+-----+--------------------------------------------------------------
// in_ch    | in  | target_x, target_y (signed Q8 cm)
// out_ch   | out | reachable, hip/knee/ankle angle, three servo targets (1/64 deg)
// cfg_ch   | in  | index (0 upper link, 1 lower link), data (13 bit Q8 cm)
//
// One target per cycle while the chain advances; each result passes the front end,
// the 28-cell square root chain, the 24-stage angle units and the back end in turn.
// rst_n is synchronous: it clears the valid line, the output buffer and sets
// both link lengths to 9.5 cm. A two-entry output buffer takes results; the
// whole chain holds only while that buffer is full and out_ch is not taking one.
module two_link_leg_inverse_kinematics (
  input  logic              clk,
  input  logic              rst_n,
  tlik_in_if.sink           in_ch,
  tlik_out_if.source        out_ch,
  tlik_cfg_if.sink          cfg_ch
);

  localparam int FRONT    = 7;   // input, products, sums, limits, clamp, squares, radicands
  localparam int PIPE_LEN = FRONT + tlik_pkg::ROOT_W + tlik_pkg::ATAN_LAT + 2;

  typedef struct packed {
    logic                                reach;
    logic signed [tlik_pkg::COORD_W-1:0] x;
    logic signed [tlik_pkg::COORD_W-1:0] y;
    logic signed [tlik_pkg::NUM_W-1:0]   num2;
    logic signed [tlik_pkg::NB_W-1:0]    nb;
  } side_t;

  typedef struct packed {
    logic                                reachable;
    logic signed [tlik_pkg::ANGLE_W-1:0] hip;
    logic signed [tlik_pkg::ANGLE_W-1:0] knee;
    logic signed [tlik_pkg::ANGLE_W-1:0] ankle;
    logic signed [tlik_pkg::ANGLE_W-1:0] hip_servo;
    logic signed [tlik_pkg::ANGLE_W-1:0] knee_servo;
    logic signed [tlik_pkg::ANGLE_W-1:0] ankle_servo;
  } res_t;

  // ---------------------------------------------------------------------------
  // Link length registers
  // ---------------------------------------------------------------------------
  logic [tlik_pkg::LINK_W-1:0] upper_len_r;
  logic [tlik_pkg::LINK_W-1:0] lower_len_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_len_r <= tlik_pkg::LINK_RESET;
      lower_len_r <= tlik_pkg::LINK_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        tlik_pkg::REG_UPPER_LEN: upper_len_r <= cfg_ch.data;
        tlik_pkg::REG_LOWER_LEN: lower_len_r <= cfg_ch.data;
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: one advance signal moves every stage
  // ---------------------------------------------------------------------------
  logic [1:0]          cnt_r;
  logic                head_r;
  logic                adv;
  logic                in_fire;
  logic                push;
  logic                pop;
  logic [PIPE_LEN-1:0] vld_r;

  assign adv         = (cnt_r != 2'd2) || out_ch.ready;
  assign in_ch.ready = adv;
  assign in_fire     = in_ch.valid && adv;
  assign push        = adv && vld_r[PIPE_LEN-1];
  assign pop         = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_LEN-2:0], in_fire};
    end
  end

  // ---------------------------------------------------------------------------
  // Front end: squares, link products, reach test, cosine numerators
  // ---------------------------------------------------------------------------
  logic signed [tlik_pkg::COORD_W-1:0]   x0_r, y0_r, xa_r, ya_r, xb_r, yb_r;
  logic signed [tlik_pkg::COORD_W-1:0]   xc_r, yc_r, xd_r, yd_r, xe_r, ye_r;
  logic signed [2*tlik_pkg::COORD_W-1:0] xsq_full, ysq_full;
  logic [tlik_pkg::SQ_W-1:0]             xsq_r, ysq_r;
  logic [tlik_pkg::LSQ_W-1:0]            l1sq_r, l2sq_r, l12_r;
  logic [tlik_pkg::DSQ_W-1:0]            dsqb_r, dsqc_r;
  logic [tlik_pkg::DEN_W-1:0]            sqsum_r, denb_r, denc_r, lo_r;
  logic signed [tlik_pkg::DEN_W-1:0]     lsqdiff_r;
  logic [tlik_pkg::LSQ_W-1:0]            l1sqb_r, l1sqc_r, l1sqd_r;
  logic signed [tlik_pkg::WIDE_W-1:0]    num_raw_r, nbc_r, den_s;
  logic [tlik_pkg::LIM_W-1:0]            hi_r, dsqd_r;
  logic                                  nz_r;
  logic                                  reachd_r, reache_r;
  logic signed [tlik_pkg::NUM_W-1:0]     num2_nxt, num2d_r, num2e_r;
  logic [tlik_pkg::DEN_W-1:0]            dend_r;
  logic signed [tlik_pkg::NB_W-1:0]      nbd_r, nbe_r;
  logic signed [2*tlik_pkg::NUM_W-1:0]   numsq_full;
  logic signed [2*tlik_pkg::NB_W-1:0]    nbsq_full;
  logic [tlik_pkg::DSQR_W-1:0]           densq_r, numsq_r;
  logic [tlik_pkg::NBSQ_W-1:0]           nbsq_r, hyp_ext;
  logic [tlik_pkg::HYP_W-1:0]            hyp_prod;
  logic [tlik_pkg::RAD_W-1:0]            hyp_r;

  assign xsq_full = x0_r * x0_r;
  assign ysq_full = y0_r * y0_r;

  always_comb begin
    den_s = $signed(tlik_pkg::WIDE_W'(denc_r));
    if (num_raw_r > den_s) begin
      num2_nxt = tlik_pkg::NUM_W'(den_s);
    end else if (num_raw_r < -den_s) begin
      num2_nxt = tlik_pkg::NUM_W'(-den_s);
    end else begin
      num2_nxt = tlik_pkg::NUM_W'(num_raw_r);
    end
  end

  assign numsq_full = num2d_r * num2d_r;
  assign nbsq_full  = nbd_r * nbd_r;
  assign hyp_prod   = tlik_pkg::HYP_W'(dsqd_r) * tlik_pkg::HYP_W'(l1sqd_r);
  assign hyp_ext    = tlik_pkg::NBSQ_W'(hyp_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      // input register
      x0_r <= in_ch.target_x;
      y0_r <= in_ch.target_y;
      // products
      xsq_r  <= tlik_pkg::SQ_W'(unsigned'(xsq_full));
      ysq_r  <= tlik_pkg::SQ_W'(unsigned'(ysq_full));
      l1sq_r <= tlik_pkg::LSQ_W'(upper_len_r) * tlik_pkg::LSQ_W'(upper_len_r);
      l2sq_r <= tlik_pkg::LSQ_W'(lower_len_r) * tlik_pkg::LSQ_W'(lower_len_r);
      l12_r  <= tlik_pkg::LSQ_W'(upper_len_r) * tlik_pkg::LSQ_W'(lower_len_r);
      xa_r   <= x0_r;
      ya_r   <= y0_r;
      // sums
      dsqb_r    <= tlik_pkg::DSQ_W'(xsq_r) + tlik_pkg::DSQ_W'(ysq_r);
      sqsum_r   <= tlik_pkg::DEN_W'(l1sq_r) + tlik_pkg::DEN_W'(l2sq_r);
      lsqdiff_r <= $signed(tlik_pkg::DEN_W'(l1sq_r)) - $signed(tlik_pkg::DEN_W'(l2sq_r));
      denb_r    <= {l12_r, 1'b0};
      l1sqb_r   <= l1sq_r;
      xb_r      <= xa_r;
      yb_r      <= ya_r;
      // reach limits and raw numerators
      num_raw_r <= $signed(tlik_pkg::WIDE_W'(dsqb_r)) - $signed(tlik_pkg::WIDE_W'(sqsum_r));
      nbc_r     <= $signed(tlik_pkg::WIDE_W'(dsqb_r)) + tlik_pkg::WIDE_W'(lsqdiff_r);
      hi_r      <= tlik_pkg::LIM_W'(sqsum_r) + tlik_pkg::LIM_W'(denb_r);
      lo_r      <= sqsum_r - denb_r;
      nz_r      <= (dsqb_r != '0);
      dsqc_r    <= dsqb_r;
      denc_r    <= denb_r;
      l1sqc_r   <= l1sqb_r;
      xc_r      <= xb_r;
      yc_r      <= yb_r;
      // reach decision and cosine clamp
      reachd_r <= nz_r && (dsqc_r <= tlik_pkg::DSQ_W'(hi_r))
                       && (dsqc_r >= tlik_pkg::DSQ_W'(lo_r));
      num2d_r  <= num2_nxt;
      nbd_r    <= tlik_pkg::NB_W'(nbc_r);
      dsqd_r   <= tlik_pkg::LIM_W'(dsqc_r);
      dend_r   <= denc_r;
      l1sqd_r  <= l1sqc_r;
      xd_r     <= xc_r;
      yd_r     <= yc_r;
      // squares for both radicands
      densq_r  <= tlik_pkg::DSQR_W'(dend_r) * tlik_pkg::DSQR_W'(dend_r);
      numsq_r  <= tlik_pkg::DSQR_W'(unsigned'(numsq_full));
      nbsq_r   <= tlik_pkg::NBSQ_W'(unsigned'(nbsq_full));
      hyp_r    <= {hyp_prod, 2'b00};
      reache_r <= reachd_r;
      num2e_r  <= num2d_r;
      nbe_r    <= nbd_r;
      xe_r     <= xd_r;
      ye_r     <= yd_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Radicands and the two square root chains
  // ---------------------------------------------------------------------------
  tlik_pkg::sqrt_t knee_sq_r [0:tlik_pkg::ROOT_W];
  tlik_pkg::sqrt_t beta_sq_r [0:tlik_pkg::ROOT_W];
  side_t           side_r    [0:tlik_pkg::ROOT_W];
  tlik_pkg::sqrt_t knee_sq_nxt;
  tlik_pkg::sqrt_t beta_sq_nxt;
  side_t           side_nxt;

  always_comb begin
    knee_sq_nxt.rad  = tlik_pkg::RAD_W'(densq_r - numsq_r);
    knee_sq_nxt.rem  = '0;
    knee_sq_nxt.root = '0;
    // no sine term once nb^2 reaches the hypotenuse square
    beta_sq_nxt.rad  = (nbsq_r >= hyp_ext) ? '0 : tlik_pkg::RAD_W'(hyp_ext - nbsq_r);
    beta_sq_nxt.rem  = '0;
    beta_sq_nxt.root = '0;
    side_nxt.reach = reache_r;
    side_nxt.x     = xe_r;
    side_nxt.y     = ye_r;
    side_nxt.num2  = num2e_r;
    side_nxt.nb    = nbe_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      knee_sq_r[0] <= knee_sq_nxt;
      beta_sq_r[0] <= beta_sq_nxt;
      side_r[0]    <= side_nxt;
      for (int k = 0; k < tlik_pkg::ROOT_W; k++) begin
        side_r[k+1] <= side_r[k];
      end
    end
  end

  for (genvar g = 0; g < tlik_pkg::ROOT_W; g++) begin : g_sqrt
    tlik_sqrt_cell u_knee_sqrt (
      .clk (clk),
      .en  (adv),
      .d   (knee_sq_r[g]),
      .q_r (knee_sq_r[g+1])
    );
    tlik_sqrt_cell u_beta_sqrt (
      .clk (clk),
      .en  (adv),
      .d   (beta_sq_r[g]),
      .q_r (beta_sq_r[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Three angle units in step: knee angle, beta, and the target bearing
  // ---------------------------------------------------------------------------
  side_t                                  sd;
  logic signed [tlik_pkg::ATAN_IN_W-1:0]  knee_a, knee_b, beta_a, beta_b, gam_a, gam_b;
  logic signed [tlik_pkg::ZW-1:0]         th2, beta, gam;
  logic                                   reach_dly_r [0:tlik_pkg::ATAN_LAT-1];

  assign sd     = side_r[tlik_pkg::ROOT_W];
  assign knee_a = $signed(tlik_pkg::ATAN_IN_W'(knee_sq_r[tlik_pkg::ROOT_W].root));
  assign knee_b = tlik_pkg::ATAN_IN_W'(sd.num2);
  assign beta_a = $signed(tlik_pkg::ATAN_IN_W'(beta_sq_r[tlik_pkg::ROOT_W].root));
  assign beta_b = tlik_pkg::ATAN_IN_W'(sd.nb);
  assign gam_a  = tlik_pkg::ATAN_IN_W'(sd.x);
  assign gam_b  = tlik_pkg::ATAN_IN_W'(sd.y);

  tlik_atan2 u_knee_atan (.clk(clk), .en(adv), .a(knee_a), .b(knee_b), .angle(th2));
  tlik_atan2 u_beta_atan (.clk(clk), .en(adv), .a(beta_a), .b(beta_b), .angle(beta));
  tlik_atan2 u_gam_atan  (.clk(clk), .en(adv), .a(gam_a),  .b(gam_b),  .angle(gam));

  always_ff @(posedge clk) begin
    if (adv) begin
      reach_dly_r[0] <= sd.reach;
      for (int k = 0; k < tlik_pkg::ATAN_LAT - 1; k++) begin
        reach_dly_r[k+1] <= reach_dly_r[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Back end: hip angle, rounding to 1/64 degree
  // ---------------------------------------------------------------------------
  logic signed [tlik_pkg::ZW-1:0]      th1_r, th2g_r;
  logic                                reachg_r, reachh_r;
  logic signed [tlik_pkg::ZW-1:0]      hip_full, knee_full, ankle_full;
  logic signed [tlik_pkg::ANGLE_W-1:0] hip_r, knee_r, ankle_r;

  assign hip_full   = (th1_r + tlik_pkg::ROUND_HALF) >>> tlik_pkg::OUT_SHIFT;
  assign knee_full  = (th2g_r + tlik_pkg::ROUND_HALF) >>> tlik_pkg::OUT_SHIFT;
  assign ankle_full = (tlik_pkg::ROUND_HALF - th1_r - th2g_r) >>> tlik_pkg::OUT_SHIFT;

  always_ff @(posedge clk) begin
    if (adv) begin
      th1_r    <= gam - beta;
      th2g_r   <= th2;
      reachg_r <= reach_dly_r[tlik_pkg::ATAN_LAT-1];
      hip_r    <= tlik_pkg::ANGLE_W'(hip_full);
      knee_r   <= tlik_pkg::ANGLE_W'(knee_full);
      ankle_r  <= tlik_pkg::ANGLE_W'(ankle_full);
      reachh_r <= reachg_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Servo targets and the two-entry output buffer
  // ---------------------------------------------------------------------------
  res_t res_nxt;
  res_t buf_r [0:1];
  res_t head;
  logic tail;

  always_comb begin
    res_nxt = '0;
    if (reachh_r) begin
      res_nxt.reachable   = 1'b1;
      res_nxt.hip         = hip_r;
      res_nxt.knee        = knee_r;
      res_nxt.ankle       = ankle_r;
      res_nxt.hip_servo   = tlik_pkg::NINETY_OUT - hip_r;
      res_nxt.knee_servo  = knee_r;
      res_nxt.ankle_servo = tlik_pkg::NINETY_OUT + ankle_r;
    end
  end

  // when full, a push lands in the slot being read out this cycle
  assign tail = head_r ^ cnt_r[0];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[tail] <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      head_r <= 1'b0;
    end else begin
      if (pop) begin
        head_r <= ~head_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head                      = buf_r[head_r];
  assign out_ch.valid              = (cnt_r != 2'd0);
  assign out_ch.reachable          = head.reachable;
  assign out_ch.hip_angle          = head.hip;
  assign out_ch.knee_angle         = head.knee;
  assign out_ch.ankle_angle        = head.ankle;
  assign out_ch.hip_servo_target   = head.hip_servo;
  assign out_ch.knee_servo_target  = head.knee_servo;
  assign out_ch.ankle_servo_target = head.ankle_servo;

endmodule

// ===== tb/two_link_leg_inverse_kinematics_test.sv =====
`timescale 1ns / 1ps

module two_link_leg_inverse_kinematics_test;

  localparam int  WATCHDOG_LIMIT = 3000;
  localparam int  DRAIN_CYCLES   = 80;   // pipeline is 61 deep, leave margin
  localparam int  ITEMS_PER_SET  = 340;
  localparam int  LONG_HOLD      = 400;
  localparam int  HOLD_AT_ITEM   = 150;
  localparam logic [tlik_pkg::CFG_IDX_W-1:0] REG_SPARE    = 2'd3;  // unmapped register index
  localparam logic [tlik_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;  // unmapped register index

  // atan(2^-i), degrees scaled by 2^20
  localparam longint STEP_ANGLE [24] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7};

  typedef struct packed {
    logic signed [tlik_pkg::COORD_W-1:0] x;
    logic signed [tlik_pkg::COORD_W-1:0] y;
  } target_t;

  typedef struct packed {
    logic                                reachable;
    logic signed [tlik_pkg::ANGLE_W-1:0] hip;
    logic signed [tlik_pkg::ANGLE_W-1:0] knee;
    logic signed [tlik_pkg::ANGLE_W-1:0] ankle;
    logic signed [tlik_pkg::ANGLE_W-1:0] hip_servo;
    logic signed [tlik_pkg::ANGLE_W-1:0] knee_servo;
    logic signed [tlik_pkg::ANGLE_W-1:0] ankle_servo;
  } pose_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tlik_in_if  in_ch();
  tlik_out_if out_ch();
  tlik_cfg_if cfg_ch();

  two_link_leg_inverse_kinematics i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  always #4 clk = ~clk;

  // Link lengths as the block should hold them
  logic [tlik_pkg::LINK_W-1:0] upper_len = tlik_pkg::LINK_RESET;
  logic [tlik_pkg::LINK_W-1:0] lower_len = tlik_pkg::LINK_RESET;

  target_t pending_targets[$];
  pose_t   expected_poses[$];

  int  targets_sent = 0;
  int  poses_seen = 0;
  int  unreachable_seen = 0;
  int  errors = 0;
  int  idle_cycles = 0;
  bit  in_taken = 1'b0;
  bit  no_idle = 1'b0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  // Angle of vector (b, a), degrees * 2^20, by vectoring rotation
  function automatic longint vector_angle(longint a, longint b);
    longint xr, yr, z, t, ma, mb, m;
    z = 0;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    m = (ma > mb) ? ma : mb;
    if (m == 0) return 0;
    while (m < (64'sd1 <<< 40)) begin
      m *= 2;
      a *= 2;
      b *= 2;
    end
    if (b < 0) begin
      if (a >= 0) begin
        xr = a; yr = -b; z = tlik_pkg::NINETY_Q;
      end else begin
        xr = -a; yr = b; z = -tlik_pkg::NINETY_Q;
      end
    end else begin
      xr = b; yr = a;
    end
    for (int i = 0; i < tlik_pkg::CORDIC_STEPS && i < 24; i++) begin
      t = xr;
      if (yr >= 0) begin
        xr += yr >>> i;
        yr -= t >>> i;
        z += STEP_ANGLE[i];
      end else begin
        xr -= yr >>> i;
        yr += t >>> i;
        z -= STEP_ANGLE[i];
      end
    end
    return z;
  endfunction

  function automatic longint round_angle(longint acc);
    return (acc + 8192) >>> 14;
  endfunction

  function automatic pose_t solve_leg(target_t tg);
    longint x, y, l1, l2, dsq, sum, diff, num2, den2, nb, hyp2, s2, sb;
    longint th1, th2, hip, knee, ankle;
    pose_t p;
    x = tg.x;
    y = tg.y;
    l1 = upper_len;
    l2 = lower_len;
    dsq = x * x + y * y;
    sum = l1 + l2;
    diff = (l1 > l2) ? l1 - l2 : l2 - l1;
    p = '0;
    if (dsq == 0 || dsq > sum * sum || dsq < diff * diff) return p;
    num2 = dsq - l1 * l1 - l2 * l2;
    den2 = 2 * l1 * l2;
    if (num2 > den2) num2 = den2;
    if (num2 < -den2) num2 = -den2;
    s2 = longint'(int_sqrt(den2 * den2 - num2 * num2));
    th2 = vector_angle(s2, num2);
    nb = dsq + l1 * l1 - l2 * l2;
    hyp2 = 4 * dsq * l1 * l1;
    sb = (nb * nb >= hyp2) ? 0 : longint'(int_sqrt(hyp2 - nb * nb));
    th1 = vector_angle(x, y) - vector_angle(sb, nb);
    hip = round_angle(th1);
    knee = round_angle(th2);
    ankle = round_angle(-(th1 + th2));
    p.reachable = 1'b1;
    p.hip = hip[tlik_pkg::ANGLE_W-1:0];
    p.knee = knee[tlik_pkg::ANGLE_W-1:0];
    p.ankle = ankle[tlik_pkg::ANGLE_W-1:0];
    p.hip_servo = 16'(longint'(tlik_pkg::NINETY_OUT) - hip);
    p.knee_servo = knee[tlik_pkg::ANGLE_W-1:0];
    p.ankle_servo = 16'(longint'(tlik_pkg::NINETY_OUT) + ankle);
    return p;
  endfunction

  // Mostly in-reach targets on a random radius; a quarter is raw noise
  function automatic target_t random_target();
    target_t tg;
    longint l1, l2, lo, hi, d, x, y;
    l1 = upper_len;
    l2 = lower_len;
    hi = l1 + l2;
    lo = (l1 > l2) ? l1 - l2 : l2 - l1;
    if ($urandom_range(0, 3) == 0 || hi == 0) begin
      tg.x = $signed(tlik_pkg::COORD_W'($urandom));
      tg.y = $signed(tlik_pkg::COORD_W'($urandom));
    end else begin
      d = lo + $urandom_range(0, int'(hi - lo));
      x = longint'($urandom_range(0, int'(2 * d))) - d;
      y = longint'(int_sqrt(d * d - x * x));
      if ($urandom_range(0, 1)) y = -y;
      tg.x = x[tlik_pkg::COORD_W-1:0];
      tg.y = y[tlik_pkg::COORD_W-1:0];
    end
    return tg;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic write_reg(logic [tlik_pkg::CFG_IDX_W-1:0] idx,
                           logic [tlik_pkg::LINK_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      tlik_pkg::REG_UPPER_LEN: upper_len = val;
      tlik_pkg::REG_LOWER_LEN: lower_len = val;
      default: ;  // unmapped index, block ignores it
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic push_target(int x, int y);
    target_t tg;
    tg.x = $signed(tlik_pkg::COORD_W'(x));
    tg.y = $signed(tlik_pkg::COORD_W'(y));
    pending_targets.push_back(tg);
  endtask

  task automatic wait_idle();
    while (pending_targets.size() != 0 || expected_poses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Driver: present one target at a time, hold it until transfer
  int in_gap = 0;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.target_x = '0;
    in_ch.target_y = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always @(negedge clk) begin
    if (in_ch.valid && !in_taken) begin
      // hold the offered target
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_ch.valid <= 1'b0;
    end else if (pending_targets.size() > 0 && rst_n) begin
      in_ch.valid <= 1'b1;
      in_ch.target_x <= pending_targets[0].x;
      in_ch.target_y <= pending_targets[0].y;
      in_gap <= pick_gap();
    end else begin
      in_ch.valid <= 1'b0;
    end
    in_taken = 1'b0;
  end

  // Receiver: random back pressure plus one long hold-off
  int  out_gap = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(negedge clk) begin
    if (!hold_done && targets_sent >= HOLD_AT_ITEM) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      out_gap <= pick_gap();
    end
  end

  // Monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin
    pose_t want;
    bit moved;
    moved = 1'b0;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      target_t tg;
      tg.x = in_ch.target_x;
      tg.y = in_ch.target_y;
      expected_poses.push_back(solve_leg(tg));
      void'(pending_targets.pop_front());
      targets_sent++;
      in_taken = 1'b1;
      moved = 1'b1;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      moved = 1'b1;
      poses_seen++;
      if (expected_poses.size() == 0) begin
        $error("result with no pending target");
        errors++;
      end else begin
        want = expected_poses.pop_front();
        if (!want.reachable) unreachable_seen++;
        if (out_ch.reachable !== want.reachable) begin
          $error("reachable: expected %0d, got %0d", want.reachable, out_ch.reachable);
          errors++;
        end
        if (out_ch.hip_angle !== want.hip) begin
          $error("hip_angle: expected %0d, got %0d", want.hip, out_ch.hip_angle);
          errors++;
        end
        if (out_ch.knee_angle !== want.knee) begin
          $error("knee_angle: expected %0d, got %0d", want.knee, out_ch.knee_angle);
          errors++;
        end
        if (out_ch.ankle_angle !== want.ankle) begin
          $error("ankle_angle: expected %0d, got %0d", want.ankle, out_ch.ankle_angle);
          errors++;
        end
        if (out_ch.hip_servo_target !== want.hip_servo) begin
          $error("hip_servo_target: expected %0d, got %0d",
                 want.hip_servo, out_ch.hip_servo_target);
          errors++;
        end
        if (out_ch.knee_servo_target !== want.knee_servo) begin
          $error("knee_servo_target: expected %0d, got %0d",
                 want.knee_servo, out_ch.knee_servo_target);
          errors++;
        end
        if (out_ch.ankle_servo_target !== want.ankle_servo) begin
          $error("ankle_servo_target: expected %0d, got %0d",
                 want.ankle_servo, out_ch.ankle_servo_target);
          errors++;
        end
      end
    end
    // watchdog: count cycles without any transfer
    if (moved || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", expected_poses.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic run_random(int n);
    repeat (n) pending_targets.push_back(random_target());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: origin, coordinate extremes, reach edges at default links
    push_target(0, 0);
    push_target(32767, 32767);
    push_target(-32768, -32768);
    push_target(32767, -32768);
    push_target(-32768, 32767);
    push_target(4864, 0);
    push_target(4865, 0);
    push_target(0, 4864);
    push_target(-4864, 0);
    push_target(0, -4864);
    push_target(1, 0);
    push_target(0, 1);
    push_target(-1, -1);
    push_target(3439, 3439);
    push_target(3000, -3000);
    push_target(-2000, 1500);
    run_random(ITEMS_PER_SET);
    wait_idle();

    // Short upper link, long lower link: narrow ring
    write_reg(tlik_pkg::REG_UPPER_LEN, 13'd1);
    write_reg(tlik_pkg::REG_LOWER_LEN, 13'd8191);
    push_target(8192, 0);
    push_target(0, -8190);
    push_target(8189, 0);
    run_random(ITEMS_PER_SET);
    wait_idle();

    write_reg(tlik_pkg::REG_UPPER_LEN, 13'd8191);
    write_reg(tlik_pkg::REG_LOWER_LEN, 13'd1);
    run_random(ITEMS_PER_SET);
    wait_idle();

    // Both links at maximum, no idling in this stretch
    no_idle = 1'b1;
    write_reg(tlik_pkg::REG_LOWER_LEN, 13'd8191);
    push_target(16382, 0);
    push_target(-16382, 0);
    push_target(0, 16382);
    run_random(ITEMS_PER_SET);
    wait_idle();
    no_idle = 1'b0;

    // Zero upper link: degenerate cosine, zero-vector angle
    write_reg(tlik_pkg::REG_UPPER_LEN, 13'd0);
    write_reg(tlik_pkg::REG_LOWER_LEN, 13'd1000);
    push_target(600, 800);
    push_target(1000, 0);
    push_target(0, -1000);
    run_random(ITEMS_PER_SET / 2);
    wait_idle();

    // Unequal links, then two unmapped indices that must change nothing
    write_reg(tlik_pkg::REG_UPPER_LEN, 13'd3000);
    write_reg(tlik_pkg::REG_LOWER_LEN, 13'd1500);
    write_reg(REG_SPARE, 13'd17);
    write_reg(REG_SPARE_LO, 13'd5);
    run_random(ITEMS_PER_SET);
    wait_idle();

    $display("Ran %0d targets over six link settings, %0d results, %0d unreachable.",
             targets_sent, poses_seen, unreachable_seen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/tlik_pkg.sv
rtl/core/tlik_channels.sv
rtl/core/tlik_sqrt_cell.sv
rtl/core/tlik_norm_cell.sv
rtl/core/tlik_cordic_cell.sv
rtl/core/tlik_atan2.sv
rtl/core/two_link_leg_inverse_kinematics.sv
tb/two_link_leg_inverse_kinematics_test.sv
